>>> hdl/oplb_pkg.sv
// Shared types, codes and constants of the obstacle path overlap bounds block.
package oplb_pkg;

  localparam int unsigned MaxPathPoints = 256;
  localparam int unsigned MaxPredPoints = 64;
  localparam int unsigned MaxSteps      = 64;

  localparam int unsigned CoordW  = 31;
  localparam int unsigned LenW    = 30;
  localparam int unsigned TimeW   = 20;
  localparam int unsigned IdW     = 16;
  localparam int unsigned MarginW = 20;
  localparam int unsigned StepTW  = 14;
  localparam int unsigned StepCW  = 7;
  localparam int unsigned BoundW  = 31;
  localparam int unsigned RatioW  = 17;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 112;

  localparam logic [1:0] ActLoadPath = 2'd0;
  localparam logic [1:0] ActLoadPred = 2'd1;
  localparam logic [1:0] ActEval     = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgStepTime   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSafetyMarg = 2'd2;

  localparam logic [StepTW-1:0]  StepTimeRst  = 14'd100;
  localparam logic [StepCW-1:0]  StepCountRst = 7'd1;
  localparam logic [MarginW-1:0] MarginRst    = 20'd1024;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M2, ST_STEP, ST_P0, ST_PN, ST_SEG, ST_DIV, ST_LX, ST_LX2,
    ST_LY, ST_LY2, ST_PSTART, ST_PDIFF, ST_PSQX, ST_PSQY, ST_PCMP, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {PRD_NONE, PRD_FIRST, PRD_LAST, PRD_NEXT} pred_rd_e;

  typedef enum logic [2:0] {MUL_NONE, MUL_M2, MUL_LX, MUL_LY, MUL_SQX, MUL_SQY} mul_op_e;

  typedef struct packed {
    logic     load_path;
    logic     load_pred;
    logic     latch_eval;
    logic     step_init;
    pred_rd_e pred_rd;
    logic     save_prev;
    logic     obs_from_rd;
    logic     save_seg;
    logic     div_step;
    mul_op_e  mul_op;
    logic     add_lx;
    logic     add_ly;
    logic     path_first;
    logic     path_next;
    logic     path_diff;
    logic     path_cmp;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic pred_empty;
    logic path_empty;
    logic t_le_rd;
    logic t_ge_rd;
    logic in_seg;
    logic seg_last;
    logic d_zero;
    logic path_last;
    logic step_last;
    logic out_free;
  } status_t;

endpackage

>>> hdl/oplb_ctrl.sv
// Sequencer of the obstacle path overlap bounds block.
module oplb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_action_i,
  output logic               in_ready_o,
  input  oplb_pkg::status_t  status_i,
  output oplb_pkg::cmd_t     cmd_o
);

  oplb_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oplb_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      oplb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_action_i)
            oplb_pkg::ActLoadPath: cmd_o.load_path = 1'b1;
            oplb_pkg::ActLoadPred: cmd_o.load_pred = 1'b1;
            oplb_pkg::ActEval: begin
              if (!status_i.steps_zero) begin
                cmd_o.latch_eval = 1'b1;
                state_d = oplb_pkg::ST_M2;
              end
            end
            default: ;
          endcase
        end
      end
      oplb_pkg::ST_M2: begin
        cmd_o.mul_op = oplb_pkg::MUL_M2;
        state_d = oplb_pkg::ST_STEP;
      end
      oplb_pkg::ST_STEP: begin
        cmd_o.step_init = 1'b1;
        if (status_i.pred_empty) begin
          state_d = oplb_pkg::ST_EMIT;
        end else begin
          cmd_o.pred_rd = oplb_pkg::PRD_FIRST;
          state_d = oplb_pkg::ST_P0;
        end
      end
      oplb_pkg::ST_P0: begin
        if (status_i.t_le_rd) begin
          cmd_o.obs_from_rd = 1'b1;
          state_d = oplb_pkg::ST_PSTART;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.pred_rd = oplb_pkg::PRD_LAST;
          state_d = oplb_pkg::ST_PN;
        end
      end
      oplb_pkg::ST_PN: begin
        if (status_i.t_ge_rd) begin
          cmd_o.obs_from_rd = 1'b1;
          state_d = oplb_pkg::ST_PSTART;
        end else begin
          cmd_o.pred_rd = oplb_pkg::PRD_NEXT;
          state_d = oplb_pkg::ST_SEG;
        end
      end
      oplb_pkg::ST_SEG: begin
        if (status_i.in_seg) begin
          cmd_o.save_seg = 1'b1;
          cnt_d = '0;
          state_d = oplb_pkg::ST_DIV;
        end else if (status_i.seg_last) begin
          state_d = oplb_pkg::ST_EMIT;  // times out of order: no segment
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.pred_rd = oplb_pkg::PRD_NEXT;
        end
      end
      oplb_pkg::ST_DIV: begin
        if (status_i.d_zero) begin
          state_d = oplb_pkg::ST_LX;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'(oplb_pkg::DivSteps - 1)) state_d = oplb_pkg::ST_LX;
        end
      end
      oplb_pkg::ST_LX: begin
        cmd_o.mul_op = oplb_pkg::MUL_LX;
        state_d = oplb_pkg::ST_LX2;
      end
      oplb_pkg::ST_LX2: begin
        cmd_o.add_lx = 1'b1;
        state_d = oplb_pkg::ST_LY;
      end
      oplb_pkg::ST_LY: begin
        cmd_o.mul_op = oplb_pkg::MUL_LY;
        state_d = oplb_pkg::ST_LY2;
      end
      oplb_pkg::ST_LY2: begin
        cmd_o.add_ly = 1'b1;
        state_d = oplb_pkg::ST_PSTART;
      end
      oplb_pkg::ST_PSTART: begin
        if (status_i.path_empty) begin
          state_d = oplb_pkg::ST_EMIT;
        end else begin
          cmd_o.path_first = 1'b1;
          state_d = oplb_pkg::ST_PDIFF;
        end
      end
      oplb_pkg::ST_PDIFF: begin
        cmd_o.path_diff = 1'b1;
        state_d = oplb_pkg::ST_PSQX;
      end
      oplb_pkg::ST_PSQX: begin
        cmd_o.mul_op = oplb_pkg::MUL_SQX;
        state_d = oplb_pkg::ST_PSQY;
      end
      oplb_pkg::ST_PSQY: begin
        cmd_o.mul_op = oplb_pkg::MUL_SQY;
        state_d = oplb_pkg::ST_PCMP;
      end
      oplb_pkg::ST_PCMP: begin
        cmd_o.path_cmp = 1'b1;
        if (status_i.path_last) begin
          state_d = oplb_pkg::ST_EMIT;
        end else begin
          cmd_o.path_next = 1'b1;
          state_d = oplb_pkg::ST_PDIFF;
        end
      end
      oplb_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = status_i.step_last ? oplb_pkg::ST_IDLE : oplb_pkg::ST_STEP;
        end
      end
      default: state_d = oplb_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hdl/oplb_datapath.sv
// Stores, config registers, divider, shared multiplier and result register.
module oplb_datapath #(
  parameter int unsigned MAX_PATH_POINTS = oplb_pkg::MaxPathPoints,
  parameter int unsigned MAX_PRED_POINTS = oplb_pkg::MaxPredPoints,
  parameter int unsigned MAX_STEPS       = oplb_pkg::MaxSteps
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [oplb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [oplb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_restart_i,
  input  logic [oplb_pkg::InDataW-1:0]      in_data_i,
  input  oplb_pkg::cmd_t                    cmd_i,
  output oplb_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [oplb_pkg::OutDataW-1:0]     out_data_o,
  output logic                              out_last_o
);

  localparam int unsigned PA   = $clog2(MAX_PATH_POINTS);
  localparam int unsigned PFW  = $clog2(MAX_PATH_POINTS + 1);
  localparam int unsigned QA   = (MAX_PRED_POINTS > 1) ? $clog2(MAX_PRED_POINTS) : 1;
  localparam int unsigned QFW  = $clog2(MAX_PRED_POINTS + 1);
  localparam int unsigned CW   = oplb_pkg::CoordW;
  localparam int unsigned TW   = oplb_pkg::TimeW;
  localparam int unsigned MW   = oplb_pkg::MarginW;
  localparam int unsigned LW   = oplb_pkg::LenW;
  localparam int unsigned PWW  = 2 * CW + LW;
  localparam int unsigned QWW  = 2 * CW + TW;

  // input fields
  logic signed [CW-1:0] in_x, in_y;
  logic [LW-1:0] in_s;
  logic [TW-1:0] in_t;
  logic [oplb_pkg::IdW-1:0] in_id;
  assign in_x  = in_data_i[CW-1:0];
  assign in_y  = in_data_i[2*CW-1:CW];
  assign in_s  = in_data_i[2*CW+LW-1:2*CW];
  assign in_t  = in_data_i[2*CW+LW+TW-1:2*CW+LW];
  assign in_id = in_data_i[2*CW+LW+TW+oplb_pkg::IdW-1:2*CW+LW+TW];

  // config
  logic [oplb_pkg::StepTW-1:0] step_time_q;
  logic [oplb_pkg::StepCW-1:0] step_count_q;
  logic [MW-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q  <= oplb_pkg::StepTimeRst;
      step_count_q <= oplb_pkg::StepCountRst;
      margin_q     <= oplb_pkg::MarginRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        oplb_pkg::CfgStepTime:   step_time_q  <= cfg_data_i[oplb_pkg::StepTW-1:0];
        oplb_pkg::CfgStepCount:  step_count_q <= cfg_data_i[oplb_pkg::StepCW-1:0];
        oplb_pkg::CfgSafetyMarg: margin_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stores
  logic [PWW-1:0] path_mem [MAX_PATH_POINTS];
  logic [QWW-1:0] pred_mem [MAX_PRED_POINTS];
  logic [PWW-1:0] path_rd_q;
  logic [QWW-1:0] pred_rd_q;
  logic [PFW-1:0] path_fill_q, path_eff, j_q;
  logic [QFW-1:0] pred_fill_q, pred_eff, seg_q;
  logic [PA-1:0] path_addr;
  logic [QA-1:0] pred_addr;

  assign path_eff = in_restart_i ? '0 : path_fill_q;
  assign pred_eff = in_restart_i ? '0 : pred_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_fill_q <= '0;
      pred_fill_q <= '0;
    end else begin
      if (cmd_i.load_path) begin
        path_fill_q <= (path_eff < PFW'(MAX_PATH_POINTS)) ? path_eff + 1'b1 : path_eff;
      end
      if (cmd_i.load_pred) begin
        pred_fill_q <= (pred_eff < QFW'(MAX_PRED_POINTS)) ? pred_eff + 1'b1 : pred_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_path && (path_eff < PFW'(MAX_PATH_POINTS))) begin
      path_mem[path_eff[PA-1:0]] <= {in_s, in_y, in_x};
    end
    path_rd_q <= path_mem[path_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pred && (pred_eff < QFW'(MAX_PRED_POINTS))) begin
      pred_mem[pred_eff[QA-1:0]] <= {in_t, in_y, in_x};
    end
    pred_rd_q <= pred_mem[pred_addr];
  end

  logic [QFW-1:0] seg_inc, pred_lastidx;
  logic [PFW-1:0] j_inc;
  assign seg_inc      = seg_q + 1'b1;
  assign pred_lastidx = pred_fill_q - 1'b1;
  assign j_inc        = j_q + 1'b1;

  always_comb begin
    case (cmd_i.pred_rd)
      oplb_pkg::PRD_LAST: pred_addr = pred_lastidx[QA-1:0];
      oplb_pkg::PRD_NEXT: pred_addr = seg_inc[QA-1:0];
      default:            pred_addr = '0;
    endcase
    path_addr = cmd_i.path_next ? j_inc[PA-1:0] : '0;
  end

  // read word fields
  logic signed [CW-1:0] rq_x, rq_y, rp_x, rp_y;
  logic [TW-1:0] rq_t;
  logic [LW-1:0] rp_s;
  assign rq_x = pred_rd_q[CW-1:0];
  assign rq_y = pred_rd_q[2*CW-1:CW];
  assign rq_t = pred_rd_q[QWW-1:2*CW];
  assign rp_x = path_rd_q[CW-1:0];
  assign rp_y = path_rd_q[2*CW-1:CW];
  assign rp_s = path_rd_q[PWW-1:2*CW];

  // step state
  logic [oplb_pkg::IdW-1:0] id_q;
  logic [oplb_pkg::StepCW-1:0] steps_q, i_q;
  logic [TW-1:0] t_q, prev_t_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q, ax_q, ay_q, bx_q, by_q;
  logic [TW:0] rem_q, d_q;
  logic [oplb_pkg::RatioW-1:0] r_q;
  logic signed [CW+1:0] ox_q, oy_q;
  logic signed [54:0] prod_q;
  logic [2*MW-1:0] m2_q, sqx_q, sqy_q;
  logic [CW+1:0] adx_q, ady_q;
  logic near_q, hit_q;
  logic [LW-1:0] s_q, smin_q, smax_q;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] mul_p;
  always_comb begin
    case (cmd_i.mul_op)
      oplb_pkg::MUL_M2: begin
        mul_a = 34'(margin_q);
        mul_b = 21'(margin_q);
      end
      oplb_pkg::MUL_LX: begin
        mul_a = 34'(bx_q) - 34'(ax_q);
        mul_b = 21'(r_q);
      end
      oplb_pkg::MUL_LY: begin
        mul_a = 34'(by_q) - 34'(ay_q);
        mul_b = 21'(r_q);
      end
      oplb_pkg::MUL_SQX: begin
        mul_a = 34'(adx_q[MW-1:0]);
        mul_b = 21'(adx_q[MW-1:0]);
      end
      oplb_pkg::MUL_SQY: begin
        mul_a = 34'(ady_q[MW-1:0]);
        mul_b = 21'(ady_q[MW-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 55'(mul_a) * 55'(mul_b);
  end

  // distance
  logic signed [CW+2:0] dx, dy;
  logic [CW+1:0] adx, ady;
  assign dx  = 34'(rp_x) - 34'(ox_q);
  assign dy  = 34'(rp_y) - 34'(oy_q);
  assign adx = dx[CW+2] ? 33'(-dx) : 33'(dx);
  assign ady = dy[CW+2] ? 33'(-dy) : 33'(dy);

  logic [2*MW:0] dist2;
  assign dist2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  // divider step
  logic [TW:0] rem_sh;
  logic rem_ge;
  assign rem_ge = rem_q >= d_q;
  assign rem_sh = rem_ge ? rem_q - d_q : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_eval) begin
      id_q    <= in_id;
      steps_q <= (step_count_q > oplb_pkg::StepCW'(MAX_STEPS)) ?
                 oplb_pkg::StepCW'(MAX_STEPS) : step_count_q;
      i_q     <= '0;
      t_q     <= '0;
    end
    if (cmd_i.emit) begin
      i_q <= i_q + 1'b1;
      t_q <= t_q + TW'(step_time_q);
    end
    if (cmd_i.mul_op == oplb_pkg::MUL_M2) m2_q <= mul_p[2*MW-1:0];
    if (cmd_i.mul_op == oplb_pkg::MUL_SQX) sqx_q <= mul_p[2*MW-1:0];
    if (cmd_i.mul_op == oplb_pkg::MUL_SQY) sqy_q <= mul_p[2*MW-1:0];
    if (cmd_i.mul_op == oplb_pkg::MUL_LX || cmd_i.mul_op == oplb_pkg::MUL_LY) begin
      prod_q <= mul_p;
    end
    if (cmd_i.pred_rd == oplb_pkg::PRD_FIRST) seg_q <= '0;
    if (cmd_i.pred_rd == oplb_pkg::PRD_NEXT) seg_q <= seg_inc;
    if (cmd_i.save_prev) begin
      prev_t_q <= rq_t;
      prev_x_q <= rq_x;
      prev_y_q <= rq_y;
    end
    if (cmd_i.obs_from_rd) begin
      ox_q <= 33'(rq_x);
      oy_q <= 33'(rq_y);
    end
    if (cmd_i.save_seg) begin
      ax_q  <= prev_x_q;
      ay_q  <= prev_y_q;
      bx_q  <= rq_x;
      by_q  <= rq_y;
      rem_q <= {1'b0, t_q - prev_t_q};
      d_q   <= {1'b0, rq_t - prev_t_q};
      r_q   <= '0;
    end
    if (cmd_i.div_step) begin
      r_q   <= {r_q[oplb_pkg::RatioW-2:0], rem_ge};
      rem_q <= {rem_sh[TW-1:0], 1'b0};
    end
    if (cmd_i.add_lx) ox_q <= 33'(ax_q) + 33'(prod_q >>> 16);
    if (cmd_i.add_ly) oy_q <= 33'(ay_q) + 33'(prod_q >>> 16);
    if (cmd_i.path_first) j_q <= '0;
    if (cmd_i.path_next) j_q <= j_inc;
    if (cmd_i.path_diff) begin
      adx_q  <= adx;
      ady_q  <= ady;
      near_q <= (adx <= 33'(margin_q)) && (ady <= 33'(margin_q));
      s_q    <= rp_s;
    end
  end

  // hit tracking and result register
  localparam int unsigned BW_SUM = oplb_pkg::BoundW + 1;
  logic out_valid_q;
  logic [oplb_pkg::OutDataW-1:0] out_data_q;
  logic out_last_q;
  logic [BW_SUM-1:0] hi_sum;
  logic [oplb_pkg::BoundW-1:0] lo_b, hi_b;
  assign hi_sum = BW_SUM'(smax_q) + BW_SUM'(margin_q);
  always_comb begin
    lo_b = '0;
    hi_b = '0;
    if (hit_q) begin
      lo_b = (smin_q > LW'(margin_q)) ? oplb_pkg::BoundW'(smin_q - LW'(margin_q)) : '0;
      hi_b = hi_sum[oplb_pkg::BoundW] ? '1 : hi_sum[oplb_pkg::BoundW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.step_init) begin
      hit_q <= 1'b0;
    end else if (cmd_i.path_cmp && near_q && (dist2 <= {1'b0, m2_q})) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.path_cmp && near_q && (dist2 <= {1'b0, m2_q})) begin
      if (!hit_q || s_q < smin_q) smin_q <= s_q;
      if (!hit_q || s_q > smax_q) smax_q <= s_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= oplb_pkg::OutDataW'({hi_b, lo_b, hit_q, t_q, i_q[5:0], id_q});
      out_last_q <= (i_q + 1'b1) == steps_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    status_o.steps_zero = step_count_q == '0;
    status_o.pred_empty = pred_fill_q == '0;
    status_o.path_empty = path_fill_q == '0;
    status_o.t_le_rd    = t_q <= rq_t;
    status_o.t_ge_rd    = t_q >= rq_t;
    status_o.in_seg     = (t_q >= prev_t_q) && (t_q <= rq_t);
    status_o.seg_last   = (QFW+1)'(seg_q) + 1'b1 >= (QFW+1)'(pred_fill_q);
    status_o.d_zero     = d_q == '0;
    status_o.path_last  = (PFW+1)'(j_q) + 1'b1 >= (PFW+1)'(path_fill_q);
    status_o.step_last  = (i_q + 1'b1) == steps_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

>>> hdl/obstacle_path_overlap_bounds.sv
// Top level of the obstacle path overlap bounds block.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata point/evaluate, tuser action
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata step result, tlast final step
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A load is stored from idle. An evaluate first forms the squared margin, then
// per step runs its control states with a search over the segments, the divider
// and the lerp when interpolating (the divider stops at once on a zero-length
// segment), and per path point a difference, two squares and a compare.
// Fill counts reset to zero, no clearing pass. A stalled output holds the
// sequencer in emit; after the final step a new request is taken while it waits.
module obstacle_path_overlap_bounds #(
  parameter int unsigned MAX_PATH_POINTS = oplb_pkg::MaxPathPoints,
  parameter int unsigned MAX_PRED_POINTS = oplb_pkg::MaxPredPoints,
  parameter int unsigned MAX_STEPS       = oplb_pkg::MaxSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x[30:0], pos_y[61:31], path_s[91:62], point_time[111:92], obs_tag[127:112]
  input  logic [oplb_pkg::InDataW-1:0]  s_axis_tdata,
  // action[1:0], restart[2]
  input  logic [oplb_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_obstacle[15:0], step_index[21:16], step_moment[41:22], overlap[42],
  // s_low_bound[73:43], s_high_bound[104:74], zero fill[111:105]
  output logic [oplb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [oplb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [oplb_pkg::CfgDataW-1:0] cfg_data_i
);

  oplb_pkg::cmd_t    cmd;
  oplb_pkg::status_t status;

  // config writes are taken at any time
  assign cfg_ready_o = 1'b1;

  oplb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[1:0]),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  oplb_datapath #(
    .MAX_PATH_POINTS (MAX_PATH_POINTS),
    .MAX_PRED_POINTS (MAX_PRED_POINTS),
    .MAX_STEPS       (MAX_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_restart_i (s_axis_tuser[2]),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> dv/tb.sv
// Testbench for obstacle_path_overlap_bounds: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ActNone = 2'd3;                        // unused action code
  localparam logic [oplb_pkg::CfgIdxW-1:0] CfgNone = 2'd3;      // unused register index

  // one expected step result
  typedef struct {
    bit [oplb_pkg::IdW-1:0]    obstacle;
    bit [5:0]                  index;
    bit [oplb_pkg::TimeW-1:0]  moment;
    bit                        overlap;
    bit [oplb_pkg::BoundW-1:0] s_low;
    bit [oplb_pkg::BoundW-1:0] s_high;
    bit                        last;
  } step_result_t;

  // predictor of the overlap bounds, with its own stores and registers
  class overlap_scoreboard;
    bit [oplb_pkg::StepTW-1:0]  step_time;
    bit [oplb_pkg::StepCW-1:0]  step_count;
    bit [oplb_pkg::MarginW-1:0] margin;
    longint           path_x[oplb_pkg::MaxPathPoints];
    longint           path_y[oplb_pkg::MaxPathPoints];
    longint           path_len[oplb_pkg::MaxPathPoints];
    int               path_fill;
    longint           pred_t[oplb_pkg::MaxPredPoints];
    longint           pred_x[oplb_pkg::MaxPredPoints];
    longint           pred_y[oplb_pkg::MaxPredPoints];
    int               pred_fill;
    step_result_t     expected_steps[$];
    int               errors;

    function new();
      step_time  = oplb_pkg::StepTimeRst;
      step_count = oplb_pkg::StepCountRst;
      margin     = oplb_pkg::MarginRst;
      path_fill  = 0;
      pred_fill  = 0;
      errors     = 0;
    endfunction

    function void write_reg(bit [oplb_pkg::CfgIdxW-1:0] idx,
                            bit [oplb_pkg::CfgDataW-1:0] value);
      case (idx)
        oplb_pkg::CfgStepTime:   step_time  = value[oplb_pkg::StepTW-1:0];
        oplb_pkg::CfgStepCount:  step_count = value[oplb_pkg::StepCW-1:0];
        oplb_pkg::CfgSafetyMarg: margin     = value[oplb_pkg::MarginW-1:0];
        default: ;
      endcase
    endfunction

    // floor((b-a)*r / 2^16) added to a; arithmetic shift gives the floor
    function longint interp(longint a, longint b, longint r);
      longint p;
      p = (b - a) * r;
      return a + (p >>> 16);
    endfunction

    function bit obstacle_pos(longint t, output longint ox, output longint oy);
      longint d, r;
      ox = 0;
      oy = 0;
      if (pred_fill == 0) return 0;
      if (t <= pred_t[0]) begin
        ox = pred_x[0];
        oy = pred_y[0];
        return 1;
      end
      if (t >= pred_t[pred_fill-1]) begin
        ox = pred_x[pred_fill-1];
        oy = pred_y[pred_fill-1];
        return 1;
      end
      for (int k = 0; k + 1 < pred_fill; k++) begin
        if (t >= pred_t[k] && t <= pred_t[k+1]) begin
          d = pred_t[k+1] - pred_t[k];
          r = (d > 0) ? ((t - pred_t[k]) << 16) / d : 0;
          ox = interp(pred_x[k], pred_x[k+1], r);
          oy = interp(pred_y[k], pred_y[k+1], r);
          return 1;
        end
      end
      return 0;  // times out of order, no bracketing segment
    endfunction

    function void note_request(bit [oplb_pkg::InUserW-1:0] user,
                               bit [oplb_pkg::InDataW-1:0] data);
      bit [1:0]        act;
      longint          px, py, t, ox, oy, dx, dy, smin, smax, lo, hi;
      bit [63:0]       dist2, m2;
      bit              hit;
      int              steps;
      step_result_t    res;
      act = user[1:0];
      px  = longint'($signed(data[30:0]));
      py  = longint'($signed(data[61:31]));
      case (act)
        oplb_pkg::ActLoadPath: begin
          if (user[2]) path_fill = 0;
          if (path_fill < oplb_pkg::MaxPathPoints) begin
            path_x[path_fill]   = px;
            path_y[path_fill]   = py;
            path_len[path_fill] = data[91:62];
            path_fill++;
          end
        end
        oplb_pkg::ActLoadPred: begin
          if (user[2]) pred_fill = 0;
          if (pred_fill < oplb_pkg::MaxPredPoints) begin
            pred_t[pred_fill] = data[111:92];
            pred_x[pred_fill] = px;
            pred_y[pred_fill] = py;
            pred_fill++;
          end
        end
        oplb_pkg::ActEval: begin
          steps = (step_count > oplb_pkg::MaxSteps) ? oplb_pkg::MaxSteps : step_count;
          m2 = 64'(margin) * 64'(margin);
          for (int i = 0; i < steps; i++) begin
            t = longint'(i) * step_time;
            hit = 0;
            smin = 0;
            smax = 0;
            if (obstacle_pos(t, ox, oy)) begin
              for (int j = 0; j < path_fill; j++) begin
                dx = path_x[j] - ox;
                dy = path_y[j] - oy;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                dist2 = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
                if (dist2 <= m2) begin
                  if (!hit || path_len[j] < smin) smin = path_len[j];
                  if (!hit || path_len[j] > smax) smax = path_len[j];
                  hit = 1;
                end
              end
            end
            lo = 0;
            hi = 0;
            if (hit) begin
              lo = (smin > margin) ? smin - margin : 0;
              hi = smax + margin;
              if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
            end
            res.obstacle = data[127:112];
            res.index    = i[5:0];
            res.moment   = t[oplb_pkg::TimeW-1:0];
            res.overlap  = hit;
            res.s_low    = lo[oplb_pkg::BoundW-1:0];
            res.s_high   = hi[oplb_pkg::BoundW-1:0];
            res.last     = (i + 1 == steps);
            expected_steps.insert(expected_steps.size(), res);
          end
        end
        default: ;  // unused action is ignored
      endcase
    endfunction

    function void check_result(bit [oplb_pkg::OutDataW-1:0] data, bit last);
      step_result_t e;
      if (expected_steps.size() == 0) begin
        $error("unexpected result tdata=%h tlast=%0b", data, last);
        errors++;
        return;
      end
      e = expected_steps.pop_front();
      if (data[15:0] != e.obstacle) begin
        $error("result_obstacle exp %0d got %0d", e.obstacle, data[15:0]);
        errors++;
      end
      if (data[21:16] != e.index) begin
        $error("step_index exp %0d got %0d", e.index, data[21:16]);
        errors++;
      end
      if (data[41:22] != e.moment) begin
        $error("step_moment exp %0d got %0d", e.moment, data[41:22]);
        errors++;
      end
      if (data[42] != e.overlap) begin
        $error("overlap exp %0d got %0d", e.overlap, data[42]);
        errors++;
      end
      if (data[73:43] != e.s_low) begin
        $error("s_low_bound exp %0d got %0d", e.s_low, data[73:43]);
        errors++;
      end
      if (data[104:74] != e.s_high) begin
        $error("s_high_bound exp %0d got %0d", e.s_high, data[104:74]);
        errors++;
      end
      if (data[111:105] != '0) begin
        $error("zero fill exp 0 got %0d", data[111:105]);
        errors++;
      end
      if (last != e.last) begin
        $error("last exp %0d got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  // every request an evaluate of 64 steps over a full path with the longest stalls
  localparam longint CycleLimit = 150_000_000;
  localparam int     DrainCycles = 400;  // covers a request that yields no result

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [oplb_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic [oplb_pkg::InUserW-1:0]   s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [oplb_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [oplb_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [oplb_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  overlap_scoreboard sb = new();
  longint cycles = 0;
  int     requests_sent = 0;
  bit     calm = 0;  // no idling on either side while set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  obstacle_path_overlap_bounds u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result checking on accepted handshakes
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // receiver: random stall before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send(bit [1:0] act, bit restart, longint px, longint py,
                      longint s, longint tm, longint id);
    int gap;
    gap = calm ? 0 : $urandom_range(16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {restart, act};
    s_axis_tdata  <= {id[15:0], tm[19:0], s[29:0], py[30:0], px[30:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request({restart, act}, {id[15:0], tm[19:0], s[29:0], py[30:0], px[30:0]});
    requests_sent++;
  endtask

  // wait until every expected result has arrived, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_steps.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [oplb_pkg::CfgIdxW-1:0] idx, longint value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[oplb_pkg::CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, value[oplb_pkg::CfgDataW-1:0]);
  endtask

  task automatic set_regs(longint st, longint sc, longint mg);
    drain();
    write_reg(oplb_pkg::CfgStepTime, st);
    write_reg(oplb_pkg::CfgStepCount, sc);
    write_reg(oplb_pkg::CfgSafetyMarg, mg);
  endtask

  function automatic longint rand_coord();
    return longint'($signed($urandom())) >>> 1;  // full 31-bit signed span
  endfunction

  function automatic longint near(longint base, longint spread);
    longint v;
    v = base + longint'($urandom_range(2 * spread)) - spread;
    if (v > 1073741823) v = 1073741823;
    if (v < -1073741824) v = -1073741824;
    return v;
  endfunction

  // one random sequence: path, prediction, at times an unused action, evaluate
  task automatic scenario();
    longint bx, by, spread, horizon, tm;
    int     npath, npred, order;
    bx = (($urandom_range(3) == 0)) ? rand_coord() : near(0, 1 << 20);
    by = (($urandom_range(3) == 0)) ? rand_coord() : near(0, 1 << 20);
    spread = longint'(sb.margin) * 2 + 16;
    if ($urandom_range(3) != 0) begin
      npath = $urandom_range(1, 12);
      for (int j = 0; j < npath; j++) begin
        send(oplb_pkg::ActLoadPath, j == 0, near(bx, spread), near(by, spread),
             ($urandom_range(7) == 0) ? longint'($urandom() >> 2) : $urandom_range(100000),
             $urandom() & 20'hFFFFF, $urandom() & 16'hFFFF);
      end
    end
    if ($urandom_range(4) != 0) begin
      npred = $urandom_range(1, 6);
      order = $urandom_range(5);
      horizon = longint'(sb.step_time) * ((sb.step_count > 64) ? 64 : sb.step_count) + 1;
      tm = 0;
      for (int k = 0; k < npred; k++) begin
        case (order)
          0: tm = $urandom() & 20'hFFFFF;              // any order
          1: tm = tm + (($urandom_range(1) == 0) ? 0 : $urandom_range(200)); // repeats
          default: tm = tm + $urandom_range(horizon / npred + 1);
        endcase
        if (tm > 20'hFFFFF) tm = 20'hFFFFF;
        send(oplb_pkg::ActLoadPred, k == 0 || $urandom_range(9) != 0 && k == 0,
             near(bx, spread), near(by, spread), $urandom() >> 2, tm, $urandom() & 16'hFFFF);
      end
    end
    if ($urandom_range(9) == 0) send(ActNone, $urandom_range(1), rand_coord(), rand_coord(),
                                     $urandom() >> 2, $urandom() & 20'hFFFFF, $urandom());
    send(oplb_pkg::ActEval, $urandom_range(1), rand_coord(), rand_coord(), $urandom() >> 2,
         $urandom() & 20'hFFFFF, $urandom() & 16'hFFFF);
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stores, extremes of the fields, special cases
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 16'hFFFF);               // both stores empty
    send(oplb_pkg::ActLoadPath, 1, -1073741824, -1073741824, 0, 0, 0);
    send(oplb_pkg::ActLoadPath, 0, 1073741823, 1073741823, 30'h3FFF_FFFF, 20'hFFFFF,
         16'hFFFF);
    send(oplb_pkg::ActLoadPath, 0, 0, 0, 5000, 0, 1);
    send(oplb_pkg::ActLoadPath, 0, 700, -300, 800, 0, 2);
    send(oplb_pkg::ActEval, 1, 0, 0, 0, 0, 0);                       // prediction empty
    send(oplb_pkg::ActLoadPred, 1, 0, 0, 0, 0, 0);
    send(oplb_pkg::ActLoadPred, 0, 1073741823, 1073741823, 0, 20'hFFFFF, 0);
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 1234);
    send(ActNone, 1, 0, 0, 0, 0, 0);                                 // unused action
    send(oplb_pkg::ActLoadPred, 1, -2000, 0, 0, 50, 0);
    send(oplb_pkg::ActLoadPred, 0, 2000, 0, 0, 50, 0);               // zero-length segment
    send(oplb_pkg::ActLoadPred, 0, 0, 4000, 0, 150, 0);
    send(oplb_pkg::ActLoadPred, 0, -1073741824, -1073741824, 0, 100, 0); // out of order
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 7);
    set_regs(1, 127, 0);                                             // steps saturate
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 8);
    set_regs(10000, 0, 20'hFFFFF);                                   // no steps
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 9);
    set_regs(50, 5, 20'hFFFFF);
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 10);
    set_regs(100, 3, 1024);
    write_reg(CfgNone, 20'hFFFFF);                                   // unused register index
    send(oplb_pkg::ActLoadPred, 1, -3000, 0, 0, 0, 0);
    send(oplb_pkg::ActLoadPred, 0, 3000, -5, 0, 200, 0);
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 11);                      // interpolated steps

    // full stores: extra points are dropped, a restart still stores
    calm = 1;
    for (int j = 0; j < oplb_pkg::MaxPathPoints + 2; j++)
      send(oplb_pkg::ActLoadPath, j == 0, near(0, 5000), near(0, 5000),
           $urandom_range(1 << 20), 0, 0);
    for (int k = 0; k < oplb_pkg::MaxPredPoints + 2; k++)
      send(oplb_pkg::ActLoadPred, k == 0, near(0, 5000), near(0, 5000), 0, k * 7, 0);
    calm = 0;
    set_regs(3, 2, 4096);
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 12);
    send(oplb_pkg::ActLoadPath, 1, 0, 0, 100, 0, 0);
    send(oplb_pkg::ActLoadPred, 1, 0, 0, 0, 0, 0);
    send(oplb_pkg::ActEval, 0, 0, 0, 0, 0, 13);

    // random sequences with occasional register changes
    while (requests_sent < 470) begin
      calm = ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(9);
        set_regs((pick == 0) ? 1 : (pick == 1) ? 10000 : $urandom_range(20, 500),
                 (pick == 2) ? 64 : (pick == 3) ? 127 : (pick == 4) ? 0 : $urandom_range(1, 12),
                 (pick == 5) ? 0 : (pick == 6) ? 20'hFFFFF : $urandom_range(256, 8192));
      end
      if ($urandom_range(11) == 0) drain();  // sender holds off until all results are in
      scenario();
    end

    calm = 0;
    drain();
    if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/oplb_pkg.sv
hdl/oplb_ctrl.sv
hdl/oplb_datapath.sv
hdl/obstacle_path_overlap_bounds.sv
dv/tb.sv
